// ===== rtl/core/frdt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the failure report
// deduplication and throttling block. No dependencies.
package frdt_pkg;

	// Sizing of the recent-report table and of timestamps.
	localparam int TableDepth = 128;
	localparam int TimeBits   = 40;
	localparam int LimitCapC  = 128;
	localparam int LimitCap   = (LimitCapC < TableDepth) ? LimitCapC : TableDepth;
	localparam int IdxBits    = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int CntBits    = $clog2(TableDepth + 1);

	// Field widths.
	localparam int FpBits      = 64;
	localparam int NowBits     = 40;
	localparam int SuccBits    = 32;
	localparam int WinBits     = 32;
	localparam int LimBits     = 8;
	localparam int CfgIdxBits  = 2;
	localparam int CfgDataBits = 32;
	localparam int EntryBits   = FpBits + TimeBits;

	typedef logic [TimeBits-1:0] time_t;
	typedef logic [IdxBits-1:0]  idx_t;
	typedef logic [CntBits-1:0]  cnt_t;

	// Configuration register indexes.
	localparam logic [CfgIdxBits-1:0] REG_PERSISTENCE_WINDOW  = 2'd0;
	localparam logic [CfgIdxBits-1:0] REG_MIN_REPORT_INTERVAL = 2'd1;
	localparam logic [CfgIdxBits-1:0] REG_DUPLICATE_WINDOW    = 2'd2;
	localparam logic [CfgIdxBits-1:0] REG_REMEMBERED_LIMIT    = 2'd3;

	// Configuration register file contents.
	typedef struct packed {
		logic [WinBits-1:0] persist;
		logic [WinBits-1:0] min_interval;
		logic [WinBits-1:0] dup_window;
		logic [LimBits-1:0] limit;
	} cfg_t;

	// Command passed from the classifier to the table engine.
	typedef enum logic {
		CMD_PASS,
		CMD_CHECK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [FpBits-1:0]  fp;
		time_t              now;
	} cmd_t;

	// Table engine states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_DECIDE
	} bk_state_t;

	// Status of the table engine, watched at the top level.
	typedef struct packed {
		logic walking;
		cnt_t rd_idx;
		cnt_t count;
	} bk_status_t;

	// Elapsed time modulo the timestamp range.
	function automatic time_t elapsed(time_t now, time_t past);
		return now - past;
	endfunction

	// Ring position at an offset from the head, wrapped once at the depth.
	function automatic idx_t ring_at(idx_t head, cnt_t off);
		logic [CntBits:0] sum;
		sum = (CntBits+1)'(head) + (CntBits+1)'(off);
		if (sum >= (CntBits+1)'(TableDepth)) begin
			sum = sum - (CntBits+1)'(TableDepth);
		end
		return IdxBits'(sum);
	endfunction

	// Table limit clamped to the range from one to the cap.
	function automatic cnt_t eff_limit(logic [LimBits-1:0] lim);
		cnt_t res;
		if (lim == '0) begin
			res = CntBits'(1);
		end else if (int'(lim) > LimitCap) begin
			res = CntBits'(LimitCap);
		end else begin
			res = CntBits'(lim);
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/failure_report_dedup_throttle.sv =====
`timescale 1ns / 1ps
// Failure report deduplication and throttling, top level.
// Order: a settled item passes through the command queue and then the result register; an item
// that reaches the table is held in the back part while it walks the live entries.
// Throughput: one item per cycle when settled in the front part, while the back part is idle and
// results are popped; the table walk reads one entry per cycle and holds the back part until done.
// Reset: arst_n clears control state and restores the register reset values.
module failure_report_dedup_throttle (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             operation,
	input  logic [frdt_pkg::SuccBits-1:0]    success_count,
	input  logic                             failure_active,
	input  logic [frdt_pkg::FpBits-1:0]      fingerprint,
	input  logic                             fingerprint_valid,
	input  logic [frdt_pkg::NowBits-1:0]     now_ms,
	output logic                             empty,
	input  logic                             pop,
	output logic                             report,
	input  logic                             cfg_write,
	input  logic [frdt_pkg::CfgIdxBits-1:0]  cfg_index,
	input  logic [frdt_pkg::CfgDataBits-1:0] cfg_data
);

	frdt_pkg::cfg_t       cfg_q;
	logic                 cmd_full;
	logic                 cmd_empty;
	logic                 cmd_push;
	logic                 cmd_pop;
	frdt_pkg::cmd_t       cmd_wr;
	frdt_pkg::cmd_t       cmd_rd;
	frdt_pkg::bk_status_t bk_status;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.persist      <= '0;
			cfg_q.min_interval <= '0;
			cfg_q.dup_window   <= '0;
			cfg_q.limit        <= frdt_pkg::LimBits'(frdt_pkg::LimitCapC);
		end else if (cfg_write) begin
			unique case (cfg_index)
				frdt_pkg::REG_PERSISTENCE_WINDOW:  cfg_q.persist      <= cfg_data;
				frdt_pkg::REG_MIN_REPORT_INTERVAL: cfg_q.min_interval <= cfg_data;
				frdt_pkg::REG_DUPLICATE_WINDOW:    cfg_q.dup_window   <= cfg_data;
				frdt_pkg::REG_REMEMBERED_LIMIT:
					cfg_q.limit <= cfg_data[frdt_pkg::LimBits-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Front part: classification and observation state.
	frdt_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.operation        (operation),
		.success_count    (success_count),
		.failure_active   (failure_active),
		.fingerprint      (fingerprint),
		.fingerprint_valid(fingerprint_valid),
		.now_ms           (now_ms),
		.cfg              (cfg_q),
		.cmd_full         (cmd_full),
		.cmd_push         (cmd_push),
		.cmd_data         (cmd_wr)
	);

	// Command queue between the two parts.
	frdt_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_wr),
		.full   (cmd_full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_rd),
		.empty  (cmd_empty)
	);

	// Back part: table walk, throttling and result register.
	frdt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_empty(cmd_empty),
		.cmd_data (cmd_rd),
		.cmd_pop  (cmd_pop),
		.empty    (empty),
		.pop      (pop),
		.report   (report),
		.status   (bk_status)
	);

	// The table never holds more entries than it has rows.
	assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.count <= frdt_pkg::CntBits'(frdt_pkg::TableDepth))
		else $error("table fill count exceeds table depth");

	// The walk never reads past the live entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.walking |-> bk_status.rd_idx <= bk_status.count)
		else $error("table walk ran past the live entries");

	// A waiting positive report always finds the table non-empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && report) |-> bk_status.count != '0)
		else $error("report raised with an empty table");

	// A command is only taken from the queue when one is there.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command taken from an empty queue");

endmodule

// ===== rtl/core/frdt_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module frdt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                            wdata,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                            rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/frdt_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts observations, tracks the success counter and the
// candidate fingerprint, and issues commands to the table engine. Uses frdt_pkg.
module frdt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          operation,
	input  logic [frdt_pkg::SuccBits-1:0] success_count,
	input  logic                          failure_active,
	input  logic [frdt_pkg::FpBits-1:0]   fingerprint,
	input  logic                          fingerprint_valid,
	input  logic [frdt_pkg::NowBits-1:0]  now_ms,
	input  frdt_pkg::cfg_t                cfg,
	input  logic                          cmd_full,
	output logic                          cmd_push,
	output frdt_pkg::cmd_t                cmd_data
);

	logic                          counter_seen_q, counter_seen_d;
	logic [frdt_pkg::SuccBits-1:0] seen_q, seen_d;
	logic                          cand_present_q, cand_present_d;
	logic [frdt_pkg::FpBits-1:0]   cand_value_q, cand_value_d;
	frdt_pkg::time_t               cand_start_q, cand_start_d;
	frdt_pkg::time_t               now;
	frdt_pkg::cmd_kind_t           kind;
	logic                          accept;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign now    = frdt_pkg::TimeBits'(now_ms);

	// Classify the observation and compute the next observation state.
	always_comb begin
		counter_seen_d = counter_seen_q;
		seen_d         = seen_q;
		cand_present_d = cand_present_q;
		cand_value_d   = cand_value_q;
		cand_start_d   = cand_start_q;
		kind           = frdt_pkg::CMD_PASS;
		if (operation) begin
			cand_present_d = 1'b0;
			counter_seen_d = 1'b0;
			seen_d         = '0;
		end else if (!counter_seen_q || success_count != seen_q) begin
			seen_d         = success_count;
			counter_seen_d = 1'b1;
			cand_present_d = 1'b0;
		end else if (!failure_active || !fingerprint_valid) begin
			cand_present_d = 1'b0;
		end else if (!cand_present_q || cand_value_q != fingerprint) begin
			cand_present_d = 1'b1;
			cand_value_d   = fingerprint;
			cand_start_d   = now;
		end else if (frdt_pkg::elapsed(now, cand_start_q) >=
			frdt_pkg::TimeBits'(cfg.persist)) begin
			kind = frdt_pkg::CMD_CHECK;
		end
	end

	// Observation state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_seen_q <= 1'b0;
			cand_present_q <= 1'b0;
		end else if (accept) begin
			counter_seen_q <= counter_seen_d;
			cand_present_q <= cand_present_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seen_q       <= seen_d;
			cand_value_q <= cand_value_d;
			cand_start_q <= cand_start_d;
		end
	end

	// Every accepted transaction becomes one command.
	assign cmd_push      = accept;
	assign cmd_data.kind = kind;
	assign cmd_data.fp   = fingerprint;
	assign cmd_data.now  = now;

endmodule

// ===== rtl/core/frdt_cmd_queue.sv =====
`timescale 1ns / 1ps
// Two-entry command queue between the front part and the table engine.
// Uses frdt_pkg.
module frdt_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  frdt_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output frdt_pkg::cmd_t rd_data,
	output logic           empty
);

	frdt_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     level_q;

	assign full    = (level_q == 2'd2);
	assign empty   = (level_q == 2'd0);
	assign rd_data = entry_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				level_q <= level_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				level_q <= level_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/core/frdt_back.sv =====
`timescale 1ns / 1ps
// Back part: walks the recent-report table to expire and match entries,
// applies the report interval, appends reports and holds the result.
// Uses frdt_pkg and frdt_ram.
module frdt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  frdt_pkg::cfg_t       cfg,
	input  logic                 cmd_empty,
	input  frdt_pkg::cmd_t       cmd_data,
	output logic                 cmd_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic                 report,
	output frdt_pkg::bk_status_t status
);

	frdt_pkg::bk_state_t         state_q, state_d;
	logic [frdt_pkg::FpBits-1:0] fp_q;
	frdt_pkg::time_t             now_q;
	frdt_pkg::idx_t              head_q;
	frdt_pkg::cnt_t              count_q;
	frdt_pkg::cnt_t              rd_idx_q;
	frdt_pkg::cnt_t              kept_q;
	logic                        hit_q;
	logic                        rd_vld_s1;
	logic                        last_present_q;
	frdt_pkg::time_t             last_time_q;
	logic                        out_valid_q;
	logic                        out_report_q;

	logic                           out_free;
	logic                           rd_more;
	logic                           issue;
	logic                           emit;
	logic                           emit_report;
	logic                           keep;
	logic                           interval_ok;
	logic                           do_report;
	logic                           ram_we;
	frdt_pkg::idx_t                 ram_waddr;
	logic [frdt_pkg::EntryBits-1:0] ram_wdata;
	frdt_pkg::idx_t                 ram_raddr;
	logic [frdt_pkg::EntryBits-1:0] ram_rdata;
	logic [frdt_pkg::FpBits-1:0]    ent_fp;
	frdt_pkg::time_t                ent_time;
	frdt_pkg::idx_t                 h1, h2, slot;
	frdt_pkg::cnt_t                 c1, c2;

	// Recent-report table: fingerprint above timestamp.
	frdt_ram #(
		.Width(frdt_pkg::EntryBits),
		.Depth(frdt_pkg::TableDepth)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ent_fp   = ram_rdata[frdt_pkg::EntryBits-1:frdt_pkg::TimeBits];
	assign ent_time = ram_rdata[frdt_pkg::TimeBits-1:0];

	// Walk and decision conditions.
	assign out_free    = !out_valid_q || pop;
	assign rd_more     = (rd_idx_q < count_q);
	assign ram_raddr   = frdt_pkg::ring_at(head_q, rd_idx_q);
	assign keep        = frdt_pkg::elapsed(now_q, ent_time) <
		frdt_pkg::TimeBits'(cfg.dup_window);
	assign interval_ok = !last_present_q || !(frdt_pkg::elapsed(now_q, last_time_q) <
		frdt_pkg::TimeBits'(cfg.min_interval));
	assign do_report   = !hit_q && interval_ok;

	// Append position and table bounds after a report.
	always_comb begin
		h1 = head_q;
		c1 = kept_q;
		if (kept_q >= frdt_pkg::CntBits'(frdt_pkg::TableDepth)) begin
			h1 = frdt_pkg::ring_at(head_q, frdt_pkg::CntBits'(1));
			c1 = kept_q - frdt_pkg::CntBits'(1);
		end
		slot = frdt_pkg::ring_at(h1, c1);
		h2   = h1;
		c2   = c1 + frdt_pkg::CntBits'(1);
		if (c2 > frdt_pkg::eff_limit(cfg.limit)) begin
			h2 = frdt_pkg::ring_at(h1, frdt_pkg::CntBits'(1));
			c2 = c2 - frdt_pkg::CntBits'(1);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			frdt_pkg::BK_IDLE: begin
				if (!cmd_empty && cmd_data.kind == frdt_pkg::CMD_CHECK) begin
					state_d = frdt_pkg::BK_WALK;
				end
			end
			frdt_pkg::BK_WALK: begin
				if (!rd_more && !rd_vld_s1) begin
					state_d = frdt_pkg::BK_DECIDE;
				end
			end
			frdt_pkg::BK_DECIDE: begin
				if (out_free) begin
					state_d = frdt_pkg::BK_IDLE;
				end
			end
			default: state_d = frdt_pkg::BK_IDLE;
		endcase
	end

	// State machine outputs.
	always_comb begin
		cmd_pop     = 1'b0;
		issue       = 1'b0;
		emit        = 1'b0;
		emit_report = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = frdt_pkg::ring_at(head_q, kept_q);
		ram_wdata   = ram_rdata;
		unique case (state_q)
			frdt_pkg::BK_IDLE: begin
				if (!cmd_empty) begin
					if (cmd_data.kind == frdt_pkg::CMD_CHECK) begin
						cmd_pop = 1'b1;
					end else if (out_free) begin
						cmd_pop = 1'b1;
						emit    = 1'b1;
					end
				end
			end
			frdt_pkg::BK_WALK: begin
				issue  = rd_more;
				ram_we = rd_vld_s1 && keep;
			end
			frdt_pkg::BK_DECIDE: begin
				emit        = out_free;
				emit_report = do_report;
				ram_we      = out_free && do_report;
				ram_waddr   = slot;
				ram_wdata   = {fp_q, now_q};
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= frdt_pkg::BK_IDLE;
			head_q         <= '0;
			count_q        <= '0;
			rd_idx_q       <= '0;
			kept_q         <= '0;
			hit_q          <= 1'b0;
			rd_vld_s1      <= 1'b0;
			last_present_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (cmd_pop && cmd_data.kind == frdt_pkg::CMD_CHECK) begin
				rd_idx_q <= '0;
				kept_q   <= '0;
				hit_q    <= 1'b0;
			end
			if (issue) begin
				rd_idx_q <= rd_idx_q + frdt_pkg::CntBits'(1);
			end
			// Surviving entries are compacted toward the head and matched.
			if (state_q == frdt_pkg::BK_WALK && rd_vld_s1 && keep) begin
				kept_q <= kept_q + frdt_pkg::CntBits'(1);
				if (ent_fp == fp_q) begin
					hit_q <= 1'b1;
				end
			end
			// Commit the purged table and any report.
			if (state_q == frdt_pkg::BK_DECIDE && out_free) begin
				if (do_report) begin
					head_q         <= h2;
					count_q        <= c2;
					last_present_q <= 1'b1;
				end else begin
					count_q <= kept_q;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_data.kind == frdt_pkg::CMD_CHECK) begin
			fp_q  <= cmd_data.fp;
			now_q <= cmd_data.now;
		end
		if (state_q == frdt_pkg::BK_DECIDE && out_free && do_report) begin
			last_time_q <= now_q;
		end
		if (emit) begin
			out_report_q <= emit_report;
		end
	end

	assign empty          = !out_valid_q;
	assign report         = out_report_q;
	assign status.walking = (state_q == frdt_pkg::BK_WALK);
	assign status.rd_idx  = rd_idx_q;
	assign status.count   = count_q;

endmodule

// ===== bench/tb_failure_report_dedup_throttle.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for failure_report_dedup_throttle.
// Depends on frdt_pkg and the block's top level; a scoreboard class predicts
// every report decision while plain tasks drive the queue-style ports.
module tb_failure_report_dedup_throttle;

	localparam bit OP_OBSERVE   = 1'b0;
	localparam bit OP_RESET_OBS = 1'b1;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int POOL_SIZE    = 8;

	// One observation as presented on the input ports.
	typedef struct packed {
		bit                          op;
		bit [frdt_pkg::SuccBits-1:0] succ;
		bit                          active;
		bit [frdt_pkg::FpBits-1:0]   fp;
		bit                          valid;
		bit [frdt_pkg::NowBits-1:0]  now;
	} obs_item_t;

	// Predicts the report decision for each accepted observation and checks
	// the decisions that come back, oldest first.
	class report_scoreboard;
		bit [frdt_pkg::WinBits-1:0]  persist_win;
		bit [frdt_pkg::WinBits-1:0]  min_interval;
		bit [frdt_pkg::WinBits-1:0]  dup_window;
		bit [frdt_pkg::LimBits-1:0]  limit_reg;
		bit                          counter_seen;
		bit [frdt_pkg::SuccBits-1:0] seen_succ;
		bit                          cand_present;
		bit [frdt_pkg::FpBits-1:0]   cand_fp;
		bit [frdt_pkg::TimeBits-1:0] cand_start;
		bit                          last_present;
		bit [frdt_pkg::TimeBits-1:0] last_time;
		bit [frdt_pkg::FpBits-1:0]   tab_fp [frdt_pkg::TableDepth];
		bit [frdt_pkg::TimeBits-1:0] tab_time [frdt_pkg::TableDepth];
		int unsigned                 tab_head;
		int unsigned                 tab_count;
		bit                          report_q [$];
		int                          errors;
		int                          checked;
		int                          reports;

		function new();
			limit_reg = 8'd128;
		endfunction

		function void set_reg(logic [frdt_pkg::CfgIdxBits-1:0] idx,
				logic [frdt_pkg::CfgDataBits-1:0] data);
			case (idx)
				frdt_pkg::REG_PERSISTENCE_WINDOW:  persist_win  = data;
				frdt_pkg::REG_MIN_REPORT_INTERVAL: min_interval = data;
				frdt_pkg::REG_DUPLICATE_WINDOW:    dup_window   = data;
				frdt_pkg::REG_REMEMBERED_LIMIT:    limit_reg    = data[frdt_pkg::LimBits-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned slot(int unsigned off);
			return (tab_head + off) % frdt_pkg::TableDepth;
		endfunction

		function bit [frdt_pkg::TimeBits-1:0] since(bit [frdt_pkg::TimeBits-1:0] now,
				bit [frdt_pkg::TimeBits-1:0] past);
			return now - past;
		endfunction

		function void drop_oldest();
			if (tab_count != 0) begin
				tab_head  = slot(1);
				tab_count = tab_count - 1;
			end
		endfunction

		// Compact the table, keeping only entries younger than the window.
		function void expire(bit [frdt_pkg::TimeBits-1:0] now);
			int unsigned kept;
			int unsigned src;
			int unsigned dst;
			kept = 0;
			for (int unsigned k = 0; k < tab_count; k++) begin
				src = slot(k);
				if (since(now, tab_time[src]) < dup_window) begin
					dst           = slot(kept);
					tab_fp[dst]   = tab_fp[src];
					tab_time[dst] = tab_time[src];
					kept++;
				end
			end
			tab_count = kept;
		endfunction

		function bit listed(bit [frdt_pkg::FpBits-1:0] fp);
			for (int unsigned k = 0; k < tab_count; k++) begin
				if (tab_fp[slot(k)] == fp) return 1'b1;
			end
			return 1'b0;
		endfunction

		function void remember(bit [frdt_pkg::FpBits-1:0] fp,
				bit [frdt_pkg::TimeBits-1:0] now);
			int unsigned lim;
			int unsigned pos;
			lim = limit_reg;
			if (lim < 1) lim = 1;
			if (lim > frdt_pkg::LimitCap) lim = frdt_pkg::LimitCap;
			if (tab_count >= frdt_pkg::TableDepth) drop_oldest();
			pos           = slot(tab_count);
			tab_fp[pos]   = fp;
			tab_time[pos] = now;
			tab_count     = tab_count + 1;
			if (tab_count > lim) drop_oldest();
		endfunction

		function void clear_cand();
			cand_present = 1'b0;
			cand_fp      = '0;
			cand_start   = '0;
		endfunction

		// Report decision for one status observation.
		function bit decide(obs_item_t it);
			if (!counter_seen || it.succ != seen_succ) begin
				seen_succ    = it.succ;
				counter_seen = 1'b1;
				clear_cand();
				return 1'b0;
			end
			if (!it.active || !it.valid) begin
				clear_cand();
				return 1'b0;
			end
			if (!cand_present || cand_fp != it.fp) begin
				cand_present = 1'b1;
				cand_fp      = it.fp;
				cand_start   = it.now;
				return 1'b0;
			end
			if (since(it.now, cand_start) < persist_win) return 1'b0;
			expire(it.now);
			if (listed(it.fp)) return 1'b0;
			if (last_present && since(it.now, last_time) < min_interval) return 1'b0;
			last_present = 1'b1;
			last_time    = it.now;
			remember(it.fp, it.now);
			return 1'b1;
		endfunction

		function void note_input(obs_item_t it);
			bit rep;
			if (it.op == OP_RESET_OBS) begin
				clear_cand();
				seen_succ    = '0;
				counter_seen = 1'b0;
				rep          = 1'b0;
			end else begin
				rep = decide(it);
			end
			report_q.insert(report_q.size(), rep);
		endfunction

		function void check_result(logic rep);
			bit want;
			if (report_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR: result report=%b with no transaction pending", rep);
			end else begin
				want = report_q[0];
				report_q.delete(0);
				checked++;
				if (want) reports++;
				if (rep !== want) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: result %0d report expected %b actual %b", checked, want, rep);
				end
			end
		endfunction

		function int pending();
			return report_q.size();
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             push;
	logic                             full;
	logic                             operation;
	logic [frdt_pkg::SuccBits-1:0]    success_count;
	logic                             failure_active;
	logic [frdt_pkg::FpBits-1:0]      fingerprint;
	logic                             fingerprint_valid;
	logic [frdt_pkg::NowBits-1:0]     now_ms;
	logic                             empty;
	logic                             pop;
	logic                             report;
	logic                             cfg_write;
	logic [frdt_pkg::CfgIdxBits-1:0]  cfg_index;
	logic [frdt_pkg::CfgDataBits-1:0] cfg_data;

	report_scoreboard sb;

	bit                          send_burst;
	bit                          recv_burst;
	bit                          holdoff_req;
	int                          items_sent;
	int                          results_taken;
	int                          settings_run;
	int                          idle_cycles;
	bit [frdt_pkg::SuccBits-1:0] cur_succ;
	bit [frdt_pkg::NowBits-1:0]  cur_now;
	bit [frdt_pkg::FpBits-1:0]   cur_fp;
	bit [frdt_pkg::FpBits-1:0]   fp_pool [POOL_SIZE];

	failure_report_dedup_throttle u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.operation         (operation),
		.success_count     (success_count),
		.failure_active    (failure_active),
		.fingerprint       (fingerprint),
		.fingerprint_valid (fingerprint_valid),
		.now_ms            (now_ms),
		.empty             (empty),
		.pop               (pop),
		.report            (report),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("Timeout after %0d cycles without a transaction", idle_cycles);
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	function automatic bit [frdt_pkg::FpBits-1:0] rand_fp();
		return {$urandom, $urandom};
	endfunction

	function automatic bit [frdt_pkg::NowBits-1:0] rand_now();
		return {8'($urandom), $urandom};
	endfunction

	function automatic obs_item_t make_item(bit op, bit [frdt_pkg::SuccBits-1:0] succ,
			bit active, bit [frdt_pkg::FpBits-1:0] fp, bit valid,
			bit [frdt_pkg::NowBits-1:0] now);
		obs_item_t it;
		it.op     = op;
		it.succ   = succ;
		it.active = active;
		it.fp     = fp;
		it.valid  = valid;
		it.now    = now;
		return it;
	endfunction

	// Offer one observation after a random gap and wait until it is taken.
	// Entered and left at a falling edge.
	task automatic send_item(input obs_item_t it);
		int gap;
		if (items_sent % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
		gap = send_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation         = it.op;
		success_count     = it.succ;
		failure_active    = it.active;
		fingerprint       = it.fp;
		fingerprint_valid = it.valid;
		now_ms            = it.now;
		push              = 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_input(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every decision has come back.
	task automatic drain_block();
		push = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(input bit [31:0] persist, input bit [31:0] interval,
			input bit [31:0] window, input bit [31:0] lim_data);
		logic [frdt_pkg::CfgIdxBits-1:0] idx [4];
		logic [frdt_pkg::CfgDataBits-1:0] val [4];
		idx = '{frdt_pkg::REG_PERSISTENCE_WINDOW, frdt_pkg::REG_MIN_REPORT_INTERVAL,
			frdt_pkg::REG_DUPLICATE_WINDOW, frdt_pkg::REG_REMEMBERED_LIMIT};
		val = '{persist, interval, window, lim_data};
		for (int k = 0; k < 4; k++) begin
			cfg_write = 1'b1;
			cfg_index = idx[k];
			cfg_data  = val[k];
			sb.set_reg(idx[k], val[k]);
			@(negedge clk);
		end
		cfg_write = 1'b0;
		settings_run++;
	endtask

	// Build the next random observation. Most are well-formed runs of one
	// fingerprint under a steady success count with time moving forward.
	task automatic gen_item(input int fresh_pct, input int step_max, output obs_item_t it);
		int roll;
		int pick;
		roll = $urandom_range(0, 99);
		it   = make_item(OP_OBSERVE, cur_succ, 1'b1, cur_fp, 1'b1, cur_now);
		if (roll < 3) begin
			it = make_item(OP_RESET_OBS, $urandom, 1'($urandom), rand_fp(), 1'($urandom),
				rand_now());
		end else if (roll < 7) begin
			cur_succ = $urandom;
			it.succ  = cur_succ;
			it.active = 1'($urandom);
		end else if (roll < 11) begin
			it = make_item(OP_OBSERVE, $urandom, 1'($urandom), rand_fp(), 1'($urandom),
				rand_now());
		end else if (roll < 15) begin
			pick      = $urandom_range(0, 2);
			it.active = (pick == 1);
			it.valid  = (pick == 2);
		end else if (roll < 17) begin
			// Jump of the time base, often backward, which looks like a long wait.
			cur_now = rand_now();
			it.now  = cur_now;
		end else begin
			if ($urandom_range(0, 99) < fresh_pct) begin
				pick = $urandom_range(0, POOL_SIZE - 1);
				if ($urandom_range(0, 1) == 0) fp_pool[pick] = rand_fp();
				cur_fp = fp_pool[pick];
			end
			cur_now = cur_now + $urandom_range(0, step_max);
			it.fp   = cur_fp;
			it.now  = cur_now;
		end
	endtask

	task automatic run_phase(input bit [31:0] persist, input bit [31:0] interval,
			input bit [31:0] window, input bit [31:0] lim_data, input int fresh_pct,
			input int count, input int step_max, input bit hold);
		obs_item_t it;
		drain_block();
		set_config(persist, interval, window, lim_data);
		if (hold) holdoff_req = 1'b1;
		repeat (count) begin
			gen_item(fresh_pct, step_max, it);
			send_item(it);
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		pop = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			int stall;
			if (holdoff_req) begin
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holdoff_req = 1'b0;
			end
			if (results_taken % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
			stall = recv_burst ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				pop = 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop = 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			sb.check_result(report);
			results_taken++;
			@(negedge clk);
		end
	end

	// Main sequence: reset, directed observations, then randomized phases.
	initial begin
		obs_item_t dir [$];
		int wait_cycles;
		arst_n            = 1'b0;
		push              = 1'b0;
		operation         = OP_OBSERVE;
		success_count     = '0;
		failure_active    = 1'b0;
		fingerprint       = '0;
		fingerprint_valid = 1'b0;
		now_ms            = '0;
		cfg_write         = 1'b0;
		cfg_index         = frdt_pkg::REG_PERSISTENCE_WINDOW;
		cfg_data          = '0;
		holdoff_req       = 1'b0;
		send_burst        = 1'b0;
		recv_burst        = 1'b0;
		items_sent        = 0;
		results_taken     = 0;
		settings_run      = 0;
		idle_cycles       = 0;
		sb                = new();
		cur_succ          = $urandom;
		cur_now           = '0;
		for (int k = 0; k < POOL_SIZE; k++) fp_pool[k] = rand_fp();
		cur_fp = fp_pool[0];
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part under reset register values: zero windows, full limit.
		dir.insert(dir.size(), make_item(OP_OBSERVE, '1, 1'b1, '1, 1'b1, '0));
		dir.insert(dir.size(), make_item(OP_OBSERVE, '1, 1'b1, '1, 1'b1, '0));
		dir.insert(dir.size(), make_item(OP_OBSERVE, '1, 1'b1, '1, 1'b1, 40'd1));
		// Zero duplicate window: the same fingerprint is reported again.
		dir.insert(dir.size(), make_item(OP_OBSERVE, '1, 1'b1, '1, 1'b1, 40'd1));
		dir.insert(dir.size(), make_item(OP_OBSERVE, '1, 1'b0, '1, 1'b1, 40'd2));
		dir.insert(dir.size(), make_item(OP_OBSERVE, '1, 1'b1, '1, 1'b1, 40'd2));
		dir.insert(dir.size(), make_item(OP_OBSERVE, '1, 1'b1, '1, 1'b0, 40'd3));
		dir.insert(dir.size(), make_item(OP_OBSERVE, '1, 1'b1, '0, 1'b1, '1));
		dir.insert(dir.size(), make_item(OP_OBSERVE, '1, 1'b1, '0, 1'b1, '1));
		// Timestamp wraps past the top of its range.
		dir.insert(dir.size(), make_item(OP_OBSERVE, '1, 1'b1, '0, 1'b1, '0));
		dir.insert(dir.size(), make_item(OP_RESET_OBS, '1, 1'b1, '1, 1'b1, '1));
		dir.insert(dir.size(), make_item(OP_OBSERVE, '0, 1'b1, '0, 1'b1, 40'd5));
		dir.insert(dir.size(), make_item(OP_OBSERVE, '0, 1'b1, '0, 1'b1, 40'd5));
		dir.insert(dir.size(), make_item(OP_OBSERVE, 32'd1, 1'b1, '0, 1'b1, 40'd6));
		dir.insert(dir.size(), make_item(OP_OBSERVE, 32'd1, 1'b1, 64'hA5A5_5A5A_0F0F_F0F0,
			1'b1, 40'd6));
		// Time earlier than the candidate start counts as a long persistence.
		dir.insert(dir.size(), make_item(OP_OBSERVE, 32'd1, 1'b1, 64'hA5A5_5A5A_0F0F_F0F0,
			1'b1, 40'd3));
		dir.insert(dir.size(), make_item(OP_RESET_OBS, '0, 1'b0, '0, 1'b0, '0));
		dir.insert(dir.size(), make_item(OP_OBSERVE, 32'd1, 1'b1, 64'hA5A5_5A5A_0F0F_F0F0,
			1'b1, 40'd9));
		foreach (dir[k]) send_item(dir[k]);

		// Long duplicate window and many distinct fingerprints fill the table;
		// the result side holds off meanwhile so the input stalls.
		run_phase(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd128, 50, 450, 3, 1'b1);
		// Lowered limit while the table is still full.
		run_phase(32'd5, 32'd4, 32'd5000, ($urandom & 32'hFFFF_FF00) | 32'd3, 20, 250, 6,
			1'b0);
		run_phase(32'd20, 32'd30, 32'd200, 32'd1, 30, 200, 15, 1'b0);
		// Limits outside the range are clamped.
		run_phase(32'd2, 32'd0, 32'd100, $urandom & 32'hFFFF_FF00, 25, 150, 8, 1'b0);
		run_phase(32'd0, 32'd10, 32'd50, 32'd255, 25, 150, 8, 1'b0);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd128, 25, 100, 1000, 1'b0);
		repeat (2) begin
			run_phase($urandom_range(0, 16), $urandom_range(0, 16), $urandom_range(0, 300),
				$urandom, 30, 50, 8, 1'b0);
		end

		// Wait for every decision, then let the block settle.
		push = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		wait_cycles = 0;
		while (wait_cycles < 20) begin
			@(negedge clk);
			wait_cycles++;
		end

		$display("Covered %0d observations under %0d register settings.", items_sent,
			settings_run + 1);
		$display("Checked %0d decisions, %0d of them reports.", sb.checked, sb.reports);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d errors, %0d decisions still pending", sb.errors, sb.pending());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
